/* hw/rtl/dxt_pkg.sv */
// Shared constants, types and arithmetic helpers for the DXT block decoder.
// Used by dxt_block_texel_decoder_unit and its testbench; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dxt_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] IMAGE_SIZE_RESET = 16'd256;

    localparam logic [1:0] MODE_DXT1 = 2'd0;
    localparam logic [1:0] MODE_DXT3 = 2'd1;
    localparam logic [1:0] MODE_DXT5 = 2'd2;

    // channel order inside a packed colour
    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;

    typedef logic [2:0][7:0] t_rgb;

    // RGB565 to 8:8:8 by bit replication
    function automatic t_rgb expand565(input logic [15:0] c);
        t_rgb p;
        p[CH_R] = {c[15:11], c[15:13]};
        p[CH_G] = {c[10:5], c[10:9]};
        p[CH_B] = {c[4:0], c[4:2]};
        return p;
    endfunction

    // reciprocal multiplies, exact over the numerator ranges seen here
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [24:0] p;
        p = {15'd0, x} * 25'd21846;
        return p[23:16];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [24:0] p;
        p = {14'd0, x} * 25'd13108;
        return p[23:16];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = {14'd0, x} * 25'd9363;
        return p[23:16];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dxt_block_texel_decoder_unit.sv */
// S3TC (DXT1/DXT3/DXT5) block decoder: block in, clipped BGRA texels out.
// Depends on dxt_pkg for constants, colour expansion and reciprocal divides.
//
// Usage
//   Config channel (i_cfg_*): index 0 image width, index 1 image height, both
//   16 bit, reset 256. Always ready; write only while the block is idle.
//   Input channel (i_in_*): one transaction per compressed 4x4 block with its
//   mode, block column/row and the two 64-bit halves of the block.
//   Output channel (o_out_*): one transaction per texel lying inside the
//   image, in row order within the block, o_last on the final one.
// Path: a block passes through stages A, B and C; each texel then through the output register.
// Flow: the emitter stage hands out one texel per cycle while the output is not
//   stalled; a block that is clipped away entirely emits no texel. Two block
//   stages ahead of it let new blocks be taken while texels are still going out.
// Reset: synchronous, active low; empties all stages and restores the image
//   size to 256 x 256.
// Stall: when i_out_ready is low the output register holds and the stages
//   behind it fill up and then drop o_in_ready; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module dxt_block_texel_decoder_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dxt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dxt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // block input
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [13:0]                    i_block_col,
    input  wire logic [13:0]                    i_block_row,
    input  wire logic [63:0]                    i_alpha_word,
    input  wire logic [63:0]                    i_color_word,
    // texel output
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [15:0]                         o_texel_x,
    output logic [15:0]                         o_texel_y,
    output logic [7:0]                          o_blue,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_alpha,
    output logic                                o_last
);

    // configuration registers
    logic [15:0] r_width;
    logic [15:0] r_height;

    // stage A: captured block, expanded endpoints
    logic              r_a_valid;
    logic [1:0]        r_a_mode;
    logic [13:0]       r_a_col;
    logic [13:0]       r_a_row;
    logic [63:0]       r_a_aw;
    logic [31:0]       r_a_cidx;
    dxt_pkg::t_rgb     r_a_ep0;
    dxt_pkg::t_rgb     r_a_ep1;
    logic              r_a_three;
    logic              n_a_three;

    // stage B: numerators and visibility mask
    logic              r_b_valid;
    logic [1:0]        r_b_mode;
    logic [15:0]       r_b_bx;
    logic [15:0]       r_b_by;
    logic [63:0]       r_b_aw;
    logic [31:0]       r_b_cidx;
    dxt_pkg::t_rgb     r_b_ep0;
    dxt_pkg::t_rgb     r_b_ep1;
    logic              r_b_three;
    logic              r_b_age;
    logic [2:0][9:0]   r_b_n2;
    logic [2:0][9:0]   r_b_n3;
    logic [2:0][7:0]   r_b_avg;
    logic [5:0][10:0]  r_b_anum;
    logic [15:0]       r_b_mask;
    logic [2:0][9:0]   n_b_n2;
    logic [2:0][9:0]   n_b_n3;
    logic [2:0][7:0]   n_b_avg;
    logic [5:0][10:0]  n_b_anum;
    logic [15:0]       n_b_mask;
    logic              n_b_age;

    // stage C: full palettes, texel emitter
    logic              r_c_valid;
    logic [1:0]        r_c_mode;
    logic [15:0]       r_c_bx;
    logic [15:0]       r_c_by;
    logic [63:0]       r_c_aw;
    logic [31:0]       r_c_cidx;
    logic              r_c_three;
    logic [3:0][23:0]  r_c_pal;
    logic [7:0][7:0]   r_c_alut;
    logic [15:0]       r_c_rem;
    logic [3:0][23:0]  n_c_pal;
    logic [7:0][7:0]   n_c_alut;
    logic [15:0]       n_c_rem;

    // output stage
    logic              r_t_valid;
    logic [15:0]       r_t_x;
    logic [15:0]       r_t_y;
    dxt_pkg::t_rgb     r_t_rgb;
    logic [7:0]        r_t_alpha;
    logic              r_t_last;
    logic [15:0]       n_t_x;
    logic [15:0]       n_t_y;
    dxt_pkg::t_rgb     n_t_rgb;
    logic [7:0]        n_t_alpha;
    logic              n_t_last;

    // emitter selection
    logic [15:0]       low_bit;
    logic [15:0]       rem_rest;
    logic [3:0]        idx;
    logic [1:0]        ci;
    logic [3:0]        nib;
    logic [2:0]        aidx;

    // flow control
    logic              in_fire;
    logic              t_take;
    logic              c_emit;
    logic              c_done;
    logic              c_load_ok;
    logic              b_adv;
    logic              b_load_ok;
    logic              a_adv;
    logic              a_load_ok;

    assign o_cfg_ready = 1'b1;

    assign t_take    = !r_t_valid || i_out_ready;
    assign c_emit    = r_c_valid && (r_c_rem != 16'd0) && t_take;
    assign c_done    = r_c_valid && ((r_c_rem == 16'd0) || (c_emit && (rem_rest == 16'd0)));
    assign c_load_ok = !r_c_valid || c_done;
    assign b_adv     = r_b_valid && c_load_ok;
    assign b_load_ok = !r_b_valid || b_adv;
    assign a_adv     = r_a_valid && b_load_ok;
    assign a_load_ok = !r_a_valid || a_adv;
    assign o_in_ready = a_load_ok;
    assign in_fire   = i_in_valid && a_load_ok;

    assign n_a_three = (i_mode == dxt_pkg::MODE_DXT1) &&
                       (i_color_word[15:0] <= i_color_word[31:16]);

    // stage B arithmetic
    always_comb begin
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [10:0] w0;
        logic [10:0] w1;
        logic [8:0]  s;
        logic [3:0]  col_ok;
        logic [3:0]  row_ok;
        a0 = r_a_aw[7:0];
        a1 = r_a_aw[15:8];
        n_b_age = (a0 >= a1);
        for (int ch = 0; ch < 3; ch++) begin
            n_b_n2[ch]  = {1'b0, r_a_ep0[ch], 1'b0} + {2'b0, r_a_ep1[ch]} + 10'd1;
            n_b_n3[ch]  = {2'b0, r_a_ep0[ch]} + {1'b0, r_a_ep1[ch], 1'b0} + 10'd1;
            s           = {1'b0, r_a_ep0[ch]} + {1'b0, r_a_ep1[ch]};
            n_b_avg[ch] = s[8:1];
        end
        for (int k = 0; k < 6; k++) begin
            if (n_b_age) begin
                w0 = 11'(6 - k);
                w1 = 11'(k + 1);
                n_b_anum[k] = w0 * {3'b0, a0} + w1 * {3'b0, a1} + 11'd3;
            end else if (k < 4) begin
                w0 = 11'(4 - k);
                w1 = 11'(k + 1);
                n_b_anum[k] = w0 * {3'b0, a0} + w1 * {3'b0, a1} + 11'd2;
            end else begin
                w0 = 11'd0;
                w1 = 11'd0;
                n_b_anum[k] = 11'd0;
            end
        end
        for (int c = 0; c < 4; c++) begin
            col_ok[c] = ({1'b0, r_a_col, 2'b00} + 17'(c)) < {1'b0, r_width};
            row_ok[c] = ({1'b0, r_a_row, 2'b00} + 17'(c)) < {1'b0, r_height};
        end
        for (int t = 0; t < 16; t++) begin
            n_b_mask[t] = col_ok[t % 4] && row_ok[t / 4];
        end
    end

    // stage C palettes
    always_comb begin
        dxt_pkg::t_rgb p2;
        dxt_pkg::t_rgb p3;
        for (int ch = 0; ch < 3; ch++) begin
            p2[ch] = r_b_three ? r_b_avg[ch] : dxt_pkg::div3(r_b_n2[ch]);
            p3[ch] = r_b_three ? 8'd0 : dxt_pkg::div3(r_b_n3[ch]);
        end
        n_c_pal[0] = r_b_ep0;
        n_c_pal[1] = r_b_ep1;
        n_c_pal[2] = p2;
        n_c_pal[3] = p3;
        n_c_alut[0] = r_b_aw[7:0];
        n_c_alut[1] = r_b_aw[15:8];
        for (int k = 0; k < 6; k++) begin
            if (r_b_age) begin
                n_c_alut[k + 2] = dxt_pkg::div7(r_b_anum[k]);
            end else if (k < 4) begin
                n_c_alut[k + 2] = dxt_pkg::div5(r_b_anum[k]);
            end else if (k == 4) begin
                n_c_alut[k + 2] = 8'd0;
            end else begin
                n_c_alut[k + 2] = 8'd255;
            end
        end
        n_c_rem = b_adv ? r_b_mask : (c_emit ? rem_rest : r_c_rem);
    end

    // texel selection: lowest visible texel still pending
    always_comb begin
        low_bit  = r_c_rem & (~r_c_rem + 16'd1);
        rem_rest = r_c_rem & ~low_bit;
        idx = 4'd0;
        for (int t = 0; t < 16; t++) begin
            if (low_bit[t]) begin
                idx = idx | 4'(t);
            end
        end
        ci   = r_c_cidx[{idx, 1'b0} +: 2];
        nib  = r_c_aw[{idx, 2'b00} +: 4];
        aidx = r_c_aw[6'd16 + {2'b00, idx} * 6'd3 +: 3];
        case (r_c_mode)
            dxt_pkg::MODE_DXT1: begin
                n_t_alpha = (r_c_three && (ci == 2'd3)) ? 8'd0 : 8'd255;
            end
            dxt_pkg::MODE_DXT3: begin
                n_t_alpha = {nib, nib};
            end
            default: begin
                n_t_alpha = r_c_alut[aidx];
            end
        endcase
        n_t_rgb  = r_c_pal[ci];
        n_t_x    = r_c_bx + {14'd0, idx[1:0]};
        n_t_y    = r_c_by + {14'd0, idx[3:2]};
        n_t_last = (rem_rest == 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dxt_pkg::IMAGE_SIZE_RESET;
            r_height <= dxt_pkg::IMAGE_SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dxt_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                dxt_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_c_rem   <= 16'd0;
        end else begin
            r_a_valid <= in_fire || (r_a_valid && !a_adv);
            r_b_valid <= a_adv || (r_b_valid && !b_adv);
            r_c_valid <= b_adv || (r_c_valid && !c_done);
            r_t_valid <= c_emit || (r_t_valid && !i_out_ready);
            r_c_rem   <= n_c_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_mode  <= i_mode;
            r_a_col   <= i_block_col;
            r_a_row   <= i_block_row;
            r_a_aw    <= i_alpha_word;
            r_a_cidx  <= i_color_word[63:32];
            r_a_ep0   <= dxt_pkg::expand565(i_color_word[15:0]);
            r_a_ep1   <= dxt_pkg::expand565(i_color_word[31:16]);
            r_a_three <= n_a_three;
        end
        if (a_adv) begin
            r_b_mode  <= r_a_mode;
            r_b_bx    <= {r_a_col, 2'b00};
            r_b_by    <= {r_a_row, 2'b00};
            r_b_aw    <= r_a_aw;
            r_b_cidx  <= r_a_cidx;
            r_b_ep0   <= r_a_ep0;
            r_b_ep1   <= r_a_ep1;
            r_b_three <= r_a_three;
            r_b_age   <= n_b_age;
            r_b_n2    <= n_b_n2;
            r_b_n3    <= n_b_n3;
            r_b_avg   <= n_b_avg;
            r_b_anum  <= n_b_anum;
            r_b_mask  <= n_b_mask;
        end
        if (b_adv) begin
            r_c_mode  <= r_b_mode;
            r_c_bx    <= r_b_bx;
            r_c_by    <= r_b_by;
            r_c_aw    <= r_b_aw;
            r_c_cidx  <= r_b_cidx;
            r_c_three <= r_b_three;
            r_c_pal   <= n_c_pal;
            r_c_alut  <= n_c_alut;
        end
        if (c_emit) begin
            r_t_x     <= n_t_x;
            r_t_y     <= n_t_y;
            r_t_rgb   <= n_t_rgb;
            r_t_alpha <= n_t_alpha;
            r_t_last  <= n_t_last;
        end
    end

    assign o_out_valid = r_t_valid;
    assign o_texel_x   = r_t_x;
    assign o_texel_y   = r_t_y;
    assign o_blue      = r_t_rgb[dxt_pkg::CH_B];
    assign o_green     = r_t_rgb[dxt_pkg::CH_G];
    assign o_red       = r_t_rgb[dxt_pkg::CH_R];
    assign o_alpha     = r_t_alpha;
    assign o_last      = r_t_last;

    // every texel handed out lies inside the configured image
    a_texel_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_texel_x < r_width) && (o_texel_y < r_height)))
        else $error("texel outside image");

    // while a block is being emitted its pending set only shrinks
    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !c_done) |=> ((r_c_rem & ~$past(r_c_rem)) == 16'd0))
        else $error("pending texel set grew during emission");

    // the final texel of a block frees the emitter in the same cycle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_emit && n_t_last) |-> c_done)
        else $error("emitter held after last texel");

endmodule

`default_nettype wire

/* tb/sv/tb_dxt_block_texel_decoder_unit.sv */
// Self-checking testbench for dxt_block_texel_decoder_unit: a directed table of blocks, then
// random blocks under several image sizes. Needs dxt_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_dxt_block_texel_decoder_unit;

    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_ITEMS   = 60;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 16;
    localparam int LONG_HOLD    = 400;
    localparam int NUM_DIR      = 25;
    localparam logic [1:0] MODE_SPARE = 2'd3;   // decodes as DXT5
    localparam logic [15:0] SZ_RST = dxt_pkg::IMAGE_SIZE_RESET;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] col;
        logic [13:0] row;
        logic [63:0] alpha_word;
        logic [63:0] color_word;
    } block_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic        last;
    } texel_t;

    // typed rows carry a uniform colour {b,g,r,a}; coordinates still follow the clipping
    typedef struct packed {
        logic [15:0] w;
        logic [15:0] h;
        block_t      blk;
        logic        typed;
        logic [31:0] bgra;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [dxt_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [dxt_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [13:0] i_block_col;
    logic [13:0] i_block_row;
    logic [63:0] i_alpha_word;
    logic [63:0] i_color_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_texel_x;
    logic [15:0] o_texel_y;
    logic [7:0]  o_blue;
    logic [7:0]  o_green;
    logic [7:0]  o_red;
    logic [7:0]  o_alpha;
    logic        o_last;

    dxt_block_texel_decoder_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_block_col  (i_block_col),
        .i_block_row  (i_block_row),
        .i_alpha_word (i_alpha_word),
        .i_color_word (i_color_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_texel_x    (o_texel_x),
        .o_texel_y    (o_texel_y),
        .o_blue       (o_blue),
        .o_green      (o_green),
        .o_red        (o_red),
        .o_alpha      (o_alpha),
        .o_last       (o_last)
    );

    texel_t      expected_texels[$];
    texel_t      want;
    dir_row_t    dir_rows [NUM_DIR];
    logic [15:0] img_w;
    logic [15:0] img_h;
    int          mismatches;
    int          cycles;
    int          hold_requests;
    int          holds_done;
    logic        idle_on;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Expected texels of one block under the current image size
    function automatic void decode_block(input block_t blk, input logic typed,
                                         input logic [31:0] bgra);
        logic [15:0] ep;
        int unsigned pr[4], pg[4], pb[4], pa[4], alut[8];
        int unsigned a0, a1, ci, av, x, y, n;
        texel_t      out_tx[16];
        n = 0;
        for (int e = 0; e < 2; e++) begin
            ep = e ? blk.color_word[31:16] : blk.color_word[15:0];
            pr[e] = (int'(ep[15:11]) << 3) | (int'(ep[15:11]) >> 2);
            pg[e] = (int'(ep[10:5]) << 2) | (int'(ep[10:5]) >> 4);
            pb[e] = (int'(ep[4:0]) << 3) | (int'(ep[4:0]) >> 2);
        end
        for (int e = 0; e < 4; e++) pa[e] = 255;
        if (blk.mode != dxt_pkg::MODE_DXT1 ||
            blk.color_word[15:0] > blk.color_word[31:16]) begin
            pr[2] = (2 * pr[0] + pr[1] + 1) / 3;
            pg[2] = (2 * pg[0] + pg[1] + 1) / 3;
            pb[2] = (2 * pb[0] + pb[1] + 1) / 3;
            pr[3] = (pr[0] + 2 * pr[1] + 1) / 3;
            pg[3] = (pg[0] + 2 * pg[1] + 1) / 3;
            pb[3] = (pb[0] + 2 * pb[1] + 1) / 3;
        end else begin
            // three-colour mode: midpoint, then transparent black
            pr[2] = (pr[0] + pr[1]) / 2;
            pg[2] = (pg[0] + pg[1]) / 2;
            pb[2] = (pb[0] + pb[1]) / 2;
            pr[3] = 0;
            pg[3] = 0;
            pb[3] = 0;
            pa[3] = 0;
        end
        a0 = blk.alpha_word[7:0];
        a1 = blk.alpha_word[15:8];
        alut[0] = a0;
        alut[1] = a1;
        if (a0 >= a1) begin
            for (int k = 0; k < 6; k++)
                alut[k + 2] = ((6 - k) * a0 + (k + 1) * a1 + 3) / 7;
        end else begin
            for (int k = 0; k < 4; k++)
                alut[k + 2] = ((4 - k) * a0 + (k + 1) * a1 + 2) / 5;
            alut[6] = 0;
            alut[7] = 255;
        end
        for (int i = 0; i < 16; i++) begin
            x = 4 * int'(blk.col) + (i % 4);
            y = 4 * int'(blk.row) + (i / 4);
            if (x < img_w && y < img_h) begin
                ci = blk.color_word[32 + 2 * i +: 2];
                if (blk.mode == dxt_pkg::MODE_DXT1)
                    av = pa[ci];
                else if (blk.mode == dxt_pkg::MODE_DXT3)
                    av = int'(blk.alpha_word[4 * i +: 4]) * 17;
                else
                    av = alut[blk.alpha_word[16 + 3 * i +: 3]];
                out_tx[n].x     = x[15:0];
                out_tx[n].y     = y[15:0];
                out_tx[n].blue  = pb[ci][7:0];
                out_tx[n].green = pg[ci][7:0];
                out_tx[n].red   = pr[ci][7:0];
                out_tx[n].alpha = av[7:0];
                if (typed)
                    {out_tx[n].blue, out_tx[n].green, out_tx[n].red, out_tx[n].alpha} = bgra;
                out_tx[n].last  = 1'b0;
                n++;
            end
        end
        if (n > 0)
            out_tx[n - 1].last = 1'b1;
        for (int j = 0; j < n; j++)
            expected_texels.push_back(out_tx[j]);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned got_val);
        if (exp_val != got_val) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_texels.size() == 0) begin
                $display("%0t: texel expected none, got x=%0d y=%0d", $time,
                         o_texel_x, o_texel_y);
                mismatches++;
            end else begin
                want = expected_texels.pop_front();
                check_field("texel_x", want.x, o_texel_x);
                check_field("texel_y", want.y, o_texel_y);
                check_field("blue", want.blue, o_blue);
                check_field("green", want.green, o_green);
                check_field("red", want.red, o_red);
                check_field("alpha", want.alpha, o_alpha);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Receiver: short random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [dxt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == dxt_pkg::CFG_IMAGE_WIDTH)
            img_w = val;
        else
            img_h = val;
    endtask

    // Reconfigure only once the decoder has gone quiet
    task automatic set_image_size(input logic [15:0] w, input logic [15:0] h);
        if (w != img_w || h != img_h) begin
            i_in_valid <= 1'b0;
            while (expected_texels.size() != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
            if (w != img_w)
                write_reg(dxt_pkg::CFG_IMAGE_WIDTH, w);
            if (h != img_h)
                write_reg(dxt_pkg::CFG_IMAGE_HEIGHT, h);
            i_cfg_valid <= 1'b0;
        end
    endtask

    // Returns at the edge that accepts the transaction; valid is left high
    task automatic offer_block(input block_t blk, input logic typed, input logic [31:0] bgra);
        i_in_valid   <= 1'b1;
        i_mode       <= blk.mode;
        i_block_col  <= blk.col;
        i_block_row  <= blk.row;
        i_alpha_word <= blk.alpha_word;
        i_color_word <= blk.color_word;
        do @(posedge i_clk); while (!o_in_ready);
        decode_block(blk, typed, bgra);
    endtask

    task automatic sender_pause();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    initial begin
        dir_rows[0]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT1, 14'd0, 14'd0,
                         64'h0, 64'h0000_0000_0000_FFFF}, 1'b1, 32'hFFFF_FFFF};
        dir_rows[1]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT1, 14'd1, 14'd0,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000}, 1'b1, 32'h0};
        dir_rows[2]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT1, 14'd2, 14'd0,
                         64'h0, 64'hAAAA_AAAA_FFFF_0000}, 1'b0, 32'h0};
        dir_rows[3]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT1, 14'd3, 14'd0,
                         64'h0, 64'hE4E4_E4E4_0000_FFFF}, 1'b0, 32'h0};
        dir_rows[4]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT1, 14'd4, 14'd0,
                         64'h0, 64'hE4E4_E4E4_8410_8410}, 1'b0, 32'h0};
        // DXT3 stays in four-colour mode even with equal endpoints
        dir_rows[5]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT3, 14'd0, 14'd1,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000}, 1'b1, 32'h0000_00FF};
        dir_rows[6]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT3, 14'd1, 14'd1,
                         64'hFEDC_BA98_7654_3210, 64'h1B1B_1B1B_F800_001F}, 1'b0, 32'h0};
        dir_rows[7]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT5, 14'd2, 14'd1,
                         64'h0000_0000_0000_00FF, 64'h0000_0000_0000_F800}, 1'b1, 32'h0000_FFFF};
        dir_rows[8]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT5, 14'd3, 14'd1,
                         64'hFFFF_FFFF_FFFF_0100, 64'h0000_0000_0000_001F}, 1'b1, 32'hFF00_00FF};
        // alpha index ramps 0..7: eight-step, six-step, equal endpoints
        dir_rows[9]  = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT5, 14'd4, 14'd1,
                         64'hFAC6_88FA_C688_20F0, 64'h3C96_5AA5_07E0_F81F}, 1'b0, 32'h0};
        dir_rows[10] = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT5, 14'd5, 14'd1,
                         64'hFAC6_88FA_C688_F020, 64'hC3C3_9696_F81F_07E0}, 1'b0, 32'h0};
        dir_rows[11] = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT5, 14'd6, 14'd1,
                         64'hFAC6_88FA_C688_7777, 64'hE4E4_E4E4_AAAA_5555}, 1'b0, 32'h0};
        dir_rows[12] = '{SZ_RST, SZ_RST, '{MODE_SPARE, 14'd0, 14'd2,
                         64'h0000_0000_0000_0080, 64'h0}, 1'b1, 32'h0000_0080};
        dir_rows[13] = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT1, 14'd16383, 14'd0,
                         64'h0, 64'hE4E4_E4E4_0000_FFFF}, 1'b1, 32'h0};
        dir_rows[14] = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT3, 14'd0, 14'd16383,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 32'h0};
        dir_rows[15] = '{SZ_RST, SZ_RST, '{dxt_pkg::MODE_DXT5, 14'd63, 14'd63,
                         64'h0123_4567_89AB_CDEF, 64'h9E37_79B9_7F4A_7C15}, 1'b0, 32'h0};
        dir_rows[16] = '{16'd10, 16'd7, '{dxt_pkg::MODE_DXT1, 14'd2, 14'd1,
                         64'h0, 64'hE4E4_E4E4_0000_FFFF}, 1'b0, 32'h0};
        dir_rows[17] = '{16'd10, 16'd7, '{dxt_pkg::MODE_DXT3, 14'd0, 14'd0,
                         64'hFEDC_BA98_7654_3210, 64'hE4E4_E4E4_001F_F800}, 1'b0, 32'h0};
        dir_rows[18] = '{16'd1, 16'd1, '{dxt_pkg::MODE_DXT1, 14'd0, 14'd0,
                         64'h0, 64'h0000_0000_0000_FFFF}, 1'b1, 32'hFFFF_FFFF};
        dir_rows[19] = '{16'd1, 16'd1, '{dxt_pkg::MODE_DXT1, 14'd1, 14'd0,
                         64'h0, 64'hE4E4_E4E4_0000_FFFF}, 1'b0, 32'h0};
        // zero width, then zero height: nothing comes out
        dir_rows[20] = '{16'd0, 16'd5, '{dxt_pkg::MODE_DXT1, 14'd0, 14'd0,
                         64'h0, 64'hE4E4_E4E4_0000_FFFF}, 1'b1, 32'h0};
        dir_rows[21] = '{16'd256, 16'd0, '{dxt_pkg::MODE_DXT5, 14'd0, 14'd0,
                         64'hFAC6_88FA_C688_20F0, 64'hE4E4_E4E4_0000_FFFF}, 1'b1, 32'h0};
        dir_rows[22] = '{16'hFFFF, 16'hFFFF, '{dxt_pkg::MODE_DXT5, 14'd16383, 14'd16383,
                         64'hFAC6_88FA_C688_20F0, 64'hE4E4_E4E4_0000_FFFF}, 1'b0, 32'h0};
        dir_rows[23] = '{16'hFFFF, 16'hFFFF, '{dxt_pkg::MODE_DXT3, 14'd0, 14'd0,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 32'hFFFF_FFFF};
        dir_rows[24] = '{16'hFFFF, 16'hFFFF, '{dxt_pkg::MODE_DXT1, 14'd16382, 14'd16383,
                         64'h0, 64'h0}, 1'b1, 32'h0000_00FF};
    end

    initial begin
        block_t      blk;
        int unsigned random_sent, phase_left, phase_no, w, h, max_col, max_row;
        mismatches    = 0;
        cycles        = 0;
        hold_requests = 0;
        holds_done    = 0;
        idle_on       = 1'b1;
        img_w         = SZ_RST;
        img_h         = SZ_RST;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = dxt_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_mode        = dxt_pkg::MODE_DXT1;
        i_block_col   = '0;
        i_block_row   = '0;
        i_alpha_word  = '0;
        i_color_word  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            set_image_size(dir_rows[r].w, dir_rows[r].h);
            offer_block(dir_rows[r].blk, dir_rows[r].typed, dir_rows[r].bgra);
            sender_pause();
        end

        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = 65535;
                    h = 65535;
                end
                1: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
                2: begin
                    w = $urandom_range(1, 65535);
                    h = $urandom_range(1, 16);
                end
                default: begin
                    w = $urandom_range(1, 64);
                    h = $urandom_range(1, 64);
                end
            endcase
            set_image_size(16'(w), 16'(h));
            // second phase: receiver holds off while blocks keep coming
            if (phase_no == 1) begin
                idle_on = 1'b0;
                hold_requests++;
            end else begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (random_sent >= RANDOM_ITEMS - TAIL_ITEMS)
                idle_on = 1'b0;
            max_col = (w + 3) / 4;
            max_row = (h + 3) / 4;
            if (max_col > 16383) max_col = 16383;
            if (max_row > 16383) max_row = 16383;
            phase_left = $urandom_range(30, 80);
            while (phase_left != 0 && random_sent < RANDOM_ITEMS) begin
                blk.mode = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    blk.col = 14'($urandom_range(0, 16383));
                    blk.row = 14'($urandom_range(0, 16383));
                end else begin
                    blk.col = 14'($urandom_range(0, max_col));
                    blk.row = 14'($urandom_range(0, max_row));
                end
                blk.alpha_word = {$urandom, $urandom};
                blk.color_word = {$urandom, $urandom};
                if ($urandom_range(0, 7) == 0) begin
                    blk.color_word[31:16] = blk.color_word[15:0];
                    blk.alpha_word[15:8]  = blk.alpha_word[7:0];
                end
                offer_block(blk, 1'b0, 32'h0);
                random_sent++;
                phase_left--;
                if (random_sent >= RANDOM_ITEMS - TAIL_ITEMS)
                    idle_on = 1'b0;
                sender_pause();
            end
            phase_no++;
        end

        i_in_valid <= 1'b0;
        while (expected_texels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* dxt_block_texel_decoder_unit.f */
hw/rtl/dxt_pkg.sv
hw/rtl/dxt_block_texel_decoder_unit.sv
tb/sv/tb_dxt_block_texel_decoder_unit.sv
